FILE: hw/rtl/msd_pkg.sv
// shared types, constants and defaults for the job dispatcher
package msd_pkg;

  localparam int MAX_SERVERS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 256;

  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam int CFG_REGW = 4;

  // register index taken from paddr[2]
  localparam logic REG_ACTIVE_SERVERS = 1'b0;
  localparam logic [CFG_REGW-1:0] ACTIVE_SERVERS_RST = 4'd8;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VISIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        command;
    logic [15:0] job_id;
    logic [7:0]  job_weight;
    logic [7:0]  job_quantity;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  server_index;
    logic        server_busy;
    logic [15:0] served_job;
    logic [15:0] time_left;
    logic        all_idle;
    logic        overflow_seen;
    logic        last_of_tick;
  } out_rsp_t;

  // one waiting job in the queue
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] ticks;
  } entry_t;

  // one server: its job, remaining time and what it reported this tick
  typedef struct packed {
    logic [15:0] job;
    logic [15:0] ticks;
    logic        rep_busy;
    logic [15:0] rep_ticks;
  } cell_t;

  typedef struct packed {
    logic en;
    logic pop_ok;
  } visit_ctl_t;

endpackage

FILE: hw/rtl/msd_queue.sv
// job queue storage: one write port, one registered read port with write bypass
module msd_queue #(
  parameter int DEPTH = msd_pkg::QUEUE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  msd_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output msd_pkg::entry_t rd_data
);

  msd_pkg::entry_t mem [DEPTH];
  msd_pkg::entry_t rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a job written into an empty queue is the next head
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_r <= wr_data;
    end else begin
      rd_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_r;

endmodule

FILE: hw/rtl/msd_cell.sv
// one server cell of the rotating ring
module msd_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift_en,
  input  msd_pkg::cell_t d_in,
  output msd_pkg::cell_t q_out
);

  msd_pkg::cell_t cell_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
    end else if (shift_en) begin
      cell_r <= d_in;
    end
  end

  assign q_out = cell_r;

endmodule

FILE: hw/rtl/msd_visit.sv
// service step applied to the server passing the ring wrap point
module msd_visit (
  input  msd_pkg::visit_ctl_t ctl,
  input  msd_pkg::entry_t     head,
  input  msd_pkg::cell_t      cur,
  output msd_pkg::cell_t      nxt,
  output logic                take
);

  logic [15:0] job_w;
  logic [15:0] ticks_w;
  logic        busy_w;

  always_comb begin
    take    = ctl.en && (cur.ticks == 16'd0) && ctl.pop_ok;
    job_w   = take ? head.id : cur.job;
    ticks_w = take ? head.ticks : cur.ticks;
    busy_w  = take || (cur.ticks != 16'd0);
    nxt     = cur;
    if (ctl.en) begin
      nxt.job       = job_w;
      nxt.rep_busy  = busy_w;
      nxt.rep_ticks = busy_w ? ticks_w : 16'd0;
      // zero-length jobs stay at zero
      nxt.ticks     = (ticks_w != 16'd0) ? ticks_w - 16'd1 : ticks_w;
    end
  end

endmodule

FILE: hw/rtl/multi_server_fcfs_job_dispatcher.sv
// top level of the multi-server first-come-first-served job dispatcher
//
//  channel | direction | handshake          | payload
//  in_     | request   | in_valid/in_ready  | msd_pkg::in_req_t
//  out_    | result    | out_valid/out_ready| msd_pkg::out_rsp_t
//  cfg_    | apb write | psel/penable       | active_servers at byte 0
//
// an enqueue request is accepted while idle; a tick first rotates every
// server cell once past the service step, then rotates the ring again,
// stalling on out_ready at each active server, to emit one result per active server.
// reset is synchronous active low and needs no clearing pass.
module multi_server_fcfs_job_dispatcher #(
  parameter int MAX_SERVERS = msd_pkg::MAX_SERVERS_DEF,
  parameter int QUEUE_DEPTH = msd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  msd_pkg::in_req_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output msd_pkg::out_rsp_t           out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [msd_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [msd_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [msd_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int SW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int NW = $clog2(MAX_SERVERS + 1);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  msd_pkg::state_t state_r, state_nxt;
  logic [SW-1:0]   step_r, step_nxt;
  logic [msd_pkg::CFG_REGW-1:0] cfg_r;
  logic [QW-1:0]   head_r, head_nxt, tail_r;
  logic [CW-1:0]   count_r;
  logic            ovf_r;

  logic [NW-1:0]   n_act;
  logic            step_act, step_last, is_last;
  logic            in_fire, enq, shift_en, take, any_busy;

  msd_pkg::cell_t      cell_q [MAX_SERVERS];
  msd_pkg::cell_t      cell_d [MAX_SERVERS];
  msd_pkg::cell_t      wrap_cell;
  msd_pkg::visit_ctl_t vctl;
  msd_pkg::entry_t     wr_entry, head_entry;

  // configuration
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= msd_pkg::ACTIVE_SERVERS_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[2] == msd_pkg::REG_ACTIVE_SERVERS)) begin
      cfg_r <= cfg_pwdata[msd_pkg::CFG_REGW-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == msd_pkg::REG_ACTIVE_SERVERS) ?
                      msd_pkg::CFG_DW'(cfg_r) : '0;

  // clamp to 1..MAX_SERVERS
  always_comb begin
    if (cfg_r == '0) begin
      n_act = NW'(1);
    end else if (int'(cfg_r) > MAX_SERVERS) begin
      n_act = NW'(MAX_SERVERS);
    end else begin
      n_act = NW'(cfg_r);
    end
  end

  assign step_act  = ((NW+1)'(step_r) < (NW+1)'(n_act));
  assign is_last   = ((NW+1)'(step_r) + (NW+1)'(1) == (NW+1)'(n_act));
  assign step_last = (step_r == SW'(MAX_SERVERS - 1));

  // control: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      msd_pkg::ST_IDLE: begin
        if (in_fire && (in_data.command == msd_pkg::CMD_TICK)) begin
          state_nxt = msd_pkg::ST_VISIT;
        end
      end
      msd_pkg::ST_VISIT: begin
        if (step_last) begin
          state_nxt = msd_pkg::ST_EMIT;
        end
      end
      msd_pkg::ST_EMIT: begin
        if (shift_en && step_last) begin
          state_nxt = msd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msd_pkg::ST_IDLE;
    endcase
  end

  // control: outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    shift_en  = 1'b0;
    vctl      = '0;
    case (state_r)
      msd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      msd_pkg::ST_VISIT: begin
        shift_en    = 1'b1;
        vctl.en     = step_act;
        vctl.pop_ok = (count_r != '0);
      end
      msd_pkg::ST_EMIT: begin
        out_valid = step_act;
        shift_en  = !step_act || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (state_r == msd_pkg::ST_IDLE) begin
      step_nxt = '0;
    end else if (shift_en) begin
      step_nxt = step_last ? '0 : step_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msd_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // queue pointers
  assign in_fire = in_valid && in_ready;
  assign enq     = in_fire && (in_data.command == msd_pkg::CMD_ENQUEUE);

  assign wr_entry.id    = in_data.job_id;
  assign wr_entry.ticks = {8'd0, in_data.job_weight} * {8'd0, in_data.job_quantity};

  assign head_nxt = !take ? head_r :
                    (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + QW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      head_r <= head_nxt;
      if (enq) begin
        if (count_r == CW'(QUEUE_DEPTH)) begin
          ovf_r <= 1'b1;
        end else begin
          tail_r  <= (tail_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + QW'(1);
          count_r <= count_r + CW'(1);
        end
      end else if (take) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  msd_queue #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (QW)
  ) u_queue (
    .clk     (clk),
    .wr_en   (enq && (count_r != CW'(QUEUE_DEPTH))),
    .wr_addr (tail_r),
    .wr_data (wr_entry),
    .rd_addr (head_nxt),
    .rd_data (head_entry)
  );

  // server ring: cell 0 passes through the service step into the last cell
  msd_visit u_visit (
    .ctl  (vctl),
    .head (head_entry),
    .cur  (cell_q[0]),
    .nxt  (wrap_cell),
    .take (take)
  );

  for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
    if (i == MAX_SERVERS - 1) begin : g_wrap
      assign cell_d[i] = wrap_cell;
    end else begin : g_link
      assign cell_d[i] = cell_q[i+1];
    end
    msd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d_in     (cell_d[i]),
      .q_out    (cell_q[i])
    );
  end

  always_comb begin
    any_busy = 1'b0;
    for (int i = 0; i < MAX_SERVERS; i++) begin
      any_busy = any_busy || (cell_q[i].ticks != 16'd0);
    end
  end

  always_comb begin
    out_data.server_index  = 3'(step_r);
    out_data.server_busy   = cell_q[0].rep_busy;
    out_data.served_job    = cell_q[0].rep_busy ? cell_q[0].job : 16'd0;
    out_data.time_left     = cell_q[0].rep_busy ? cell_q[0].rep_ticks : 16'd0;
    out_data.all_idle      = !any_busy && (count_r == '0);
    out_data.overflow_seen = ovf_r;
    out_data.last_of_tick  = is_last;
  end

endmodule

FILE: hw/rtl/msd_checker.sv
// port-level checks on the job dispatcher, bound to the top level
module msd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input msd_pkg::out_rsp_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no request is taken while results of a tick are pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken during result delivery");

  // an accepted request never yields a result in the next cycle
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early after request");

  // after the last result of a tick the block goes quiet
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_of_tick |=> !out_valid)
    else $error("result after last of tick");

  // idle servers report nothing
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.server_busy |->
      (out_data.served_job == 16'd0) && (out_data.time_left == 16'd0))
    else $error("idle server reports job data");

endmodule

bind multi_server_fcfs_job_dispatcher msd_checker u_msd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
